@@ sv/assert_macros.svh @@
// Assertion macros used by the moving average RTL.
// Concurrent checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/mcma_pkg.sv @@
`timescale 1ns / 1ps
// Package for the multichannel moving average: widths, defaults, state codes.
// No dependencies.
package mcma_pkg;

  localparam int NUM_CHANNELS_DEF = 2;
  localparam int WINDOW_MAX_DEF   = 16;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 20;
  localparam int WIN_CFG_W = 5;

  localparam logic [WIN_CFG_W-1:0] WIN_RESET   = 5'd1;
  localparam logic [WIN_CFG_W-1:0] WIN_INVALID = 5'd0;
  localparam logic [WIN_CFG_W-1:0] WIN_PASS    = 5'd1;

  localparam logic [SAMPLE_W-1:0] AVG_POS_LIM = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] AVG_NEG_LIM = 16'h8000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_STATE,
    ST_RD_HIST,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

@@ sv/multichannel_moving_average.sv @@
`timescale 1ns / 1ps
// Multichannel moving average over per-channel sample rings held in RAM.
// Depends on mcma_pkg, mcma_ram, mcma_div and assert_macros.svh.
//
//  channel | direction | signals                     | carries
//  in      | slave     | in_tvalid/tready/tdata/tuser| sample, channel
//  out     | master    | out_tvalid/tready/tdata/tuser| average, invalid flag
//  cfg     | slave     | cfg_valid/ready/data        | window size
//
// Window of two or more: one request at a time, through the state RAM read, the
//   history RAM read, the 20-step serial divider, the quotient capture, the output
//   hand-off and the idle state that takes the next request.
// Window zero or one: straight to the output hand-off, no RAM access.
// After reset a clearing pass over all NUM_CHANNELS*WINDOW_MAX slots zeroes the RAMs;
//   in_tready stays low during it.
// A result held in the output register does not stop the next request being taken.
`include "assert_macros.svh"

module multichannel_moving_average #(
  parameter int NUM_CHANNELS = mcma_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW_MAX   = mcma_pkg::WINDOW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [0:0]  in_tuser,   // [0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] average
  output logic [0:0]  out_tuser,  // [0] invalid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // window size
);

  localparam int SW     = mcma_pkg::SUM_W;
  localparam int SMW    = mcma_pkg::SAMPLE_W;
  localparam int CFW    = mcma_pkg::WIN_CFG_W;
  localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW     = $clog2(WINDOW_MAX);
  localparam int WW     = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (WW > CFW) ? WW : CFW;
  localparam int DEPTH  = NUM_CHANNELS * WINDOW_MAX;
  localparam int AW     = $clog2(DEPTH);
  localparam int STW    = SW + PW;

  mcma_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [CFW-1:0] window_r;
  logic [CHW-1:0] ch_r, ch_nxt;
  logic [SMW-1:0] smp_r, smp_nxt;
  logic [WW-1:0]  weff_r, weff_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [SMW-1:0] res_avg_r, res_avg_nxt;
  logic           res_inv_r, res_inv_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [SMW-1:0] out_avg_r, out_avg_nxt;
  logic           out_inv_r, out_inv_nxt;

  logic           in_acc;
  logic [CHW-1:0] in_ch;
  logic [WW-1:0]  weff;
  logic           out_free;

  logic           h_we, h_re;
  logic [AW-1:0]  h_waddr, h_raddr;
  logic [SMW-1:0] h_wdata, h_rdata;
  logic           st_we, st_re;
  logic [CHW-1:0] st_waddr, st_raddr;
  logic [STW-1:0] st_wdata, st_rdata;

  logic [PW-1:0]  rd_pos;
  logic [AW-1:0]  slot_rd, slot_wr;
  logic [SW-1:0]  new_sum;
  logic [PW:0]    pos_inc;
  logic [PW-1:0]  new_pos;

  logic           div_start, div_done;
  logic [SMW-1:0] div_q;

  assign in_acc    = in_tvalid && in_tready;
  assign in_ch     = (NUM_CHANNELS == 1) ? '0 : CHW'(in_tuser[0]);
  assign weff      = (CMP_W'(window_r) > CMP_W'(WINDOW_MAX)) ? WW'(WINDOW_MAX)
                                                             : WW'(window_r);
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign rd_pos  = st_rdata[PW-1:0];
  assign slot_rd = AW'(AW'(st_rdata[PW-1:0]) + AW'(AW'(ch_r) * AW'(WINDOW_MAX)));
  assign slot_wr = AW'(AW'(pos_r) + AW'(AW'(ch_r) * AW'(WINDOW_MAX)));
  assign new_sum = sum_r - {{(SW-SMW){h_rdata[SMW-1]}}, h_rdata}
                         + {{(SW-SMW){smp_r[SMW-1]}}, smp_r};
  assign pos_inc = (PW+1)'(pos_r) + (PW+1)'(1);
  assign new_pos = (pos_inc >= (PW+1)'(weff_r)) ? '0 : pos_inc[PW-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ch_nxt        = ch_r;
    smp_nxt       = smp_r;
    weff_nxt      = weff_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    res_avg_nxt   = res_avg_r;
    res_inv_nxt   = res_inv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_avg_nxt   = out_avg_r;
    out_inv_nxt   = out_inv_r;
    in_tready     = 1'b0;
    h_we          = 1'b0;
    h_waddr       = slot_wr;
    h_wdata       = smp_r;
    h_re          = 1'b0;
    h_raddr       = slot_rd;
    st_we         = 1'b0;
    st_waddr      = ch_r;
    st_wdata      = {new_sum, new_pos};
    st_re         = 1'b0;
    st_raddr      = in_ch;
    div_start     = 1'b0;
    unique case (state_r)
      mcma_pkg::ST_CLEAR: begin
        h_we     = 1'b1;
        h_waddr  = clr_cnt_r;
        h_wdata  = '0;
        st_we    = clr_cnt_r < AW'(NUM_CHANNELS);
        st_waddr = clr_cnt_r[CHW-1:0];
        st_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = mcma_pkg::ST_IDLE;
        end
      end
      mcma_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ch_nxt   = in_ch;
          smp_nxt  = in_tdata;
          weff_nxt = weff;
          priority if (window_r == mcma_pkg::WIN_INVALID) begin
            res_avg_nxt = '0;
            res_inv_nxt = 1'b1;
            state_nxt   = mcma_pkg::ST_EMIT;
          end else if (window_r == mcma_pkg::WIN_PASS) begin
            res_avg_nxt = in_tdata;
            res_inv_nxt = 1'b0;
            state_nxt   = mcma_pkg::ST_EMIT;
          end else begin
            st_re     = 1'b1;
            state_nxt = mcma_pkg::ST_RD_STATE;
          end
        end
      end
      mcma_pkg::ST_RD_STATE: begin
        h_re      = 1'b1;
        pos_nxt   = rd_pos;
        sum_nxt   = st_rdata[STW-1:PW];
        state_nxt = mcma_pkg::ST_RD_HIST;
      end
      mcma_pkg::ST_RD_HIST: begin
        h_we      = 1'b1;
        st_we     = 1'b1;
        div_start = 1'b1;
        state_nxt = mcma_pkg::ST_DIV;
      end
      mcma_pkg::ST_DIV: begin
        if (div_done) begin
          res_avg_nxt = div_q;
          res_inv_nxt = 1'b0;
          state_nxt   = mcma_pkg::ST_EMIT;
        end
      end
      mcma_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_avg_r;
          out_inv_nxt   = res_inv_r;
          state_nxt     = mcma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcma_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcma_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      window_r    <= mcma_pkg::WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_data;
      end
    end
    ch_r      <= ch_nxt;
    smp_r     <= smp_nxt;
    weff_r    <= weff_nxt;
    pos_r     <= pos_nxt;
    sum_r     <= sum_nxt;
    res_avg_r <= res_avg_nxt;
    res_inv_r <= res_inv_nxt;
    out_avg_r <= out_avg_nxt;
    out_inv_r <= out_inv_nxt;
  end

  mcma_ram #(
    .WIDTH (SMW),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  mcma_ram #(
    .WIDTH (STW),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mcma_div #(
    .DIV_W (WW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (weff_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_avg_r;
  assign out_tuser  = out_inv_r;

  `ASSERT_IMP(a_clear_quiet, clk, rst_n, state_r == mcma_pkg::ST_CLEAR, !in_tready && !out_tvalid)
  `ASSERT_IMP(a_avg_start, clk, rst_n, in_acc && (window_r > mcma_pkg::WIN_PASS), ##2 div_start)
  `ASSERT_IMP(a_done_in_div, clk, rst_n, div_done, state_r == mcma_pkg::ST_DIV)
  `ASSERT_IMP(a_invalid_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)
  `ASSERT_NXT(a_emit_shows, clk, rst_n, (state_r == mcma_pkg::ST_EMIT) && out_free, out_tvalid)

endmodule

@@ sv/mcma_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
// No dependencies.
module mcma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mcma_div.sv @@
`timescale 1ns / 1ps
// Bit-serial signed divider by a small unsigned divisor, truncating, with saturation to 16 bits.
// Depends on mcma_pkg.
module mcma_div #(
  parameter int DIV_W = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [mcma_pkg::SUM_W-1:0]  dividend,
  input  logic [DIV_W-1:0]                   divisor,
  output logic                               done,
  output logic [mcma_pkg::SAMPLE_W-1:0]      quotient
);

  localparam int SW = mcma_pkg::SUM_W;
  localparam int CW = $clog2(SW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;
  logic [SW-1:0]   num_r, num_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;

  logic [DIV_W:0]  trial;
  logic [DIV_W:0]  diff;
  logic            ge;

  assign trial = {rem_r, num_r[SW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(SW);
      neg_nxt  = dividend[SW-1];
      num_nxt  = dividend[SW-1] ? (-dividend) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[SW-2:0], ge};
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    if (neg_r) begin
      quotient = (num_r > SW'(32768)) ? mcma_pkg::AVG_NEG_LIM
                                      : mcma_pkg::SAMPLE_W'(-num_r);
    end else begin
      quotient = (num_r > SW'(32767)) ? mcma_pkg::AVG_POS_LIM
                                      : num_r[mcma_pkg::SAMPLE_W-1:0];
    end
  end

  assign done = done_r;

endmodule

@@ tb/mcma_avg_checker.sv @@
`timescale 1ns / 1ps
// Checker for multichannel_moving_average. It predicts each average from the
// accepted requests and window writes, then compares it with the result channel.
// Depends on mcma_pkg.
module mcma_avg_checker
  import mcma_pkg::*;
#(
  parameter int NUM_CH = NUM_CHANNELS_DEF,
  parameter int WMAX   = WINDOW_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] sample
  input  logic [0:0]           in_tuser,   // [0] channel
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,  // [15:0] average
  input  logic [0:0]           out_tuser,  // [0] invalid
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [WIN_CFG_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                invalid;
  } avg_result_t;

  avg_result_t                avg_expected[$];
  avg_result_t                want;
  logic [WIN_CFG_W-1:0]       window;
  logic signed [SAMPLE_W-1:0] ring [NUM_CH][WMAX];
  logic signed [SUM_W-1:0]    ch_sum [NUM_CH];
  int                         ring_pos [NUM_CH];
  int                         errs = 0;

  function automatic avg_result_t take_sample(input int ch,
                                              input logic signed [SAMPLE_W-1:0] smp);
    avg_result_t                res;
    logic signed [SAMPLE_W-1:0] oldest;
    int                         span;
    int                         acc;
    int                         quo;
    res.average = '0;
    res.invalid = 1'b0;
    if (window == WIN_INVALID) begin
      res.invalid = 1'b1;
    end else if (window == WIN_PASS) begin
      res.average = smp;
    end else begin
      span = (window > WMAX) ? WMAX : int'(window);
      oldest = ring[ch][ring_pos[ch]];
      ch_sum[ch] = ch_sum[ch] - oldest + smp;  // wraps at SUM_W bits
      ring[ch][ring_pos[ch]] = smp;
      ring_pos[ch] = (ring_pos[ch] + 1 >= span) ? 0 : ring_pos[ch] + 1;
      acc = ch_sum[ch];
      quo = acc / span;
      if (quo > 32767) begin
        quo = 32767;
      end else if (quo < -32768) begin
        quo = -32768;
      end
      res.average = quo[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      window = WIN_RESET;
      foreach (ring[c, s]) ring[c][s] = '0;
      foreach (ch_sum[c]) begin
        ch_sum[c] = '0;
        ring_pos[c] = 0;
      end
      avg_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        window = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (avg_expected.size() == 0) begin
          errs++;
          $display("%0t: result with no request pending: average %h invalid %b",
                   $time, out_tdata, out_tuser[0]);
        end else begin
          want = avg_expected.pop_front();
          if (out_tdata !== want.average) begin
            errs++;
            $display("%0t: average expected %h actual %h", $time, want.average, out_tdata);
          end
          if (out_tuser[0] !== want.invalid) begin
            errs++;
            $display("%0t: invalid expected %b actual %b", $time, want.invalid, out_tuser[0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        avg_expected.push_back(take_sample(int'(in_tuser[0]) % NUM_CH, in_tdata));
      end
    end
    mismatches <= errs;
    pending <= avg_expected.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for multichannel_moving_average: clock, reset, sample and
// window stimulus, receiver stalls and the verdict.
// Depends on mcma_pkg, mcma_avg_checker and the block itself.
module tb;
  import mcma_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_ITEMS    = 1800;
  localparam logic [15:0] SMP_MAX = 16'h7fff;
  localparam logic [15:0] SMP_MIN = 16'h8000;

  typedef enum int { RX_FREE, RX_COIN, RX_SPARSE } rx_pattern_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [WIN_CFG_W-1:0] cfg_data   = '0;

  int          mismatches;
  int          outstanding;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  rx_pattern_t rx_mode    = RX_FREE;
  int          rx_left    = 0;

  always #5 clk = ~clk;

  multichannel_moving_average i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mcma_avg_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (outstanding)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: stretches of always-ready, coin-toss and sparse acceptance
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_pattern_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(10, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= ($urandom_range(0, 1) == 1);
      default:  out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send_sample(input logic ch, input logic [15:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 30);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // window writes only once every request has come back
  task automatic set_window(input logic [WIN_CFG_W-1:0] w);
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                   sent;
    int                   phase_items;
    logic [WIN_CFG_W-1:0] w;
    logic [15:0]          smp;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // passthrough at the reset window
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b1, SMP_MIN);
    send_sample(1'b0, 16'h0000);
    set_window(WIN_INVALID);
    send_sample(1'b1, 16'hffff);
    send_sample(1'b0, 16'h3039);
    set_window(WIN_CFG_W'(WINDOW_MAX_DEF));
    for (int i = 0; i < 8; i++) begin
      send_sample(1'b0, SMP_MAX);
      send_sample(1'b1, SMP_MIN);
    end
    // shrunk window: old slots stay in the sums, so both averages saturate
    set_window(5'd2);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b1, SMP_MIN);
    // above the ring depth, clamped to it
    set_window(5'd31);
    send_sample(1'b0, 16'h0100);
    send_sample(1'b1, 16'hff00);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       w = WIN_INVALID;
        1:       w = WIN_PASS;
        2:       w = 5'd2;
        3:       w = WIN_CFG_W'(WINDOW_MAX_DEF);
        4:       w = 5'd31;
        default: w = WIN_CFG_W'($urandom_range(0, 31));
      endcase
      set_window(w);
      phase_items = $urandom_range(20, 120);
      for (int i = 0; i < phase_items; i++) begin
        case ($urandom_range(0, 9))
          0:       smp = SMP_MAX;
          1:       smp = SMP_MIN;
          2:       smp = 16'($urandom_range(0, 255)) - 16'd128;
          default: smp = 16'($urandom);
        endcase
        send_sample(1'($urandom_range(0, 1)), smp);
      end
      sent += phase_items;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/mcma_pkg.sv
sv/mcma_ram.sv
sv/mcma_div.sv
sv/multichannel_moving_average.sv
tb/mcma_avg_checker.sv
tb/tb.sv
